@@ hw/rtl/c_comment_stripper_core_defines.svh @@
// Assertion macros shared by the comment stripper checkers.
`ifndef C_COMMENT_STRIPPER_CORE_DEFINES_SVH
`define C_COMMENT_STRIPPER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CCS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/ccs_pkg.sv @@
// Types, character codes and helpers for the comment stripper.
package ccs_pkg;

  localparam int unsigned FIFO_DEPTH_DEFAULT = 4;
  localparam int unsigned LEN_W = 10;
  localparam logic [LEN_W-1:0] MAX_LIT_RESET = 10'd1000;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [3:0] {
    MODE_LINE   = 4'd0,
    MODE_MID    = 4'd1,
    MODE_SLASH  = 4'd2,
    MODE_BLOCK  = 4'd3,
    MODE_BSTAR  = 4'd4,
    MODE_LCOM   = 4'd5,
    MODE_STR    = 4'd6,
    MODE_SBS1   = 4'd7,
    MODE_SBS2   = 4'd8,
    MODE_SBS3   = 4'd9,
    MODE_CHR1   = 4'd10,
    MODE_CHRESC = 4'd11,
    MODE_CHREND = 4'd12
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_OCTAL = 3'd1,
    ST_BAD_CHAR  = 3'd2,
    ST_OVERLONG  = 3'd3,
    ST_PREMATURE = 3'd4
  } status_t;

  // One queued command: one or two result words.
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       has_byte;
    status_t    status;
  } cmd_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // Mode after a code byte other than a slash.
  function automatic mode_t code_mode(input logic [7:0] b);
    mode_t m;
    if (b == CH_NL) begin
      m = MODE_LINE;
    end else if (b == CH_DQ) begin
      m = MODE_STR;
    end else if (b == CH_SQ) begin
      m = MODE_CHR1;
    end else begin
      m = MODE_MID;
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/c_comment_stripper_core.sv @@
// Top level of the C comment stripper: front lexer, command queue, output stage.
//
// Usage:
//   Input stream s_*: one source byte per word, s_tdata[7:0] = in_byte;
//   s_tlast = end_of_text (the byte is then ignored).
//   Output stream m_*: m_tdata[7:0] = out_byte, m_tdata[10:8] = status,
//   upper bits zero; m_tuser = has_byte; m_tlast = last word caused by
//   the input word that produced it.
//   Config channel cfg_*: writes max_literal_len; always ready. Write it
//   only while no input word is in flight.
// Timing:
//   The lexer takes one input word per cycle while the queue has room. The
//   edge that accepts a word writes its command into the queue; the command
//   is then loaded into the output register, which drives m_*. Output runs
//   one word per cycle while m_tready is high; a slash that does not open a
//   comment yields two words (slash, next byte).
// Stalls:
//   When m_tready is low the output register holds and the queue fills;
//   s_tready drops only once the queue is full. After an error or end of
//   text the block halts and drops further input with s_tready high.
// Reset:
//   rst (synchronous) returns to line start, clears the halt and the queue,
//   and restores max_literal_len to 1000. No clearing pass is needed.
module c_comment_stripper_core #(
  parameter int unsigned FIFO_DEPTH = ccs_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] status, [15:11] zero
  output logic        m_tuser,   // [0] has_byte
  output logic        m_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data   // max_literal_len
);

  logic          push;
  ccs_pkg::cmd_t push_cmd;
  logic          full;
  logic          pop;
  ccs_pkg::cmd_t pop_cmd;
  logic          empty;
  logic [7:0]    out_byte;
  ccs_pkg::status_t out_status;

  // register writes are taken on any cycle
  assign cfg_ready = 1'b1;

  ccs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_byte   (s_tdata),
    .in_eot    (s_tlast),
    .in_ready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .push      (push),
    .cmd       (push_cmd),
    .full      (full)
  );

  ccs_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  ccs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .cmd        (pop_cmd),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (out_byte),
    .out_has    (m_tuser),
    .out_status (out_status),
    .out_last   (m_tlast)
  );

  // pack result fields, lowest first, padded to two bytes
  assign m_tdata = {5'd0, out_status, out_byte};

endmodule

@@ hw/rtl/ccs_fifo.sv @@
// Small register queue of commands between lexer front and output back.
module ccs_fifo #(
  parameter int unsigned DEPTH = ccs_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ccs_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output ccs_pkg::cmd_t pop_cmd,
  output logic          empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ccs_pkg::cmd_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hw/rtl/ccs_front.sv @@
// Lexer front: accepts text bytes, tracks comment/literal mode, queues results.
module ccs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_eot,
  output logic          in_ready,
  input  logic          cfg_valid,
  input  logic [ccs_pkg::LEN_W-1:0] cfg_data,
  output logic          push,
  output ccs_pkg::cmd_t cmd,
  input  logic          full
);

  ccs_pkg::mode_t mode;
  ccs_pkg::mode_t mode_next;
  logic [ccs_pkg::LEN_W-1:0] lit_len;
  logic [ccs_pkg::LEN_W-1:0] lit_len_next;
  logic [ccs_pkg::LEN_W-1:0] max_len;
  logic halted;
  logic halted_next;

  logic accept;
  logic step;
  logic in_lit;
  logic [ccs_pkg::LEN_W-1:0] len_inc;
  logic overlong;
  logic cmd_push;

  assign in_ready = halted || !full;
  assign accept   = in_valid && in_ready;
  assign step     = accept && !halted;
  assign in_lit   = (mode == ccs_pkg::MODE_STR) || (mode == ccs_pkg::MODE_SBS1) ||
                    (mode == ccs_pkg::MODE_SBS2) || (mode == ccs_pkg::MODE_SBS3);
  assign len_inc  = lit_len + 1'b1;
  assign overlong = in_lit && (len_inc >= max_len);
  assign push     = step && cmd_push;

  // next state
  always_comb begin
    mode_next    = mode;
    lit_len_next = lit_len;
    halted_next  = halted;
    if (step) begin
      if (in_eot || overlong) begin
        halted_next = 1'b1;
      end else begin
        if (in_lit) begin
          lit_len_next = len_inc;
        end
        case (mode)
          ccs_pkg::MODE_SLASH: begin
            if (in_byte == ccs_pkg::CH_STAR) begin
              mode_next = ccs_pkg::MODE_BLOCK;
            end else if (in_byte == ccs_pkg::CH_SLASH) begin
              mode_next = ccs_pkg::MODE_LCOM;
            end else begin
              mode_next = ccs_pkg::code_mode(in_byte);
              if (in_byte == ccs_pkg::CH_DQ) lit_len_next = 10'd1;
            end
          end
          ccs_pkg::MODE_BLOCK: begin
            if (in_byte == ccs_pkg::CH_STAR) mode_next = ccs_pkg::MODE_BSTAR;
          end
          ccs_pkg::MODE_BSTAR: begin
            if (in_byte == ccs_pkg::CH_SLASH) begin
              mode_next = ccs_pkg::MODE_MID;
            end else if (in_byte != ccs_pkg::CH_STAR) begin
              mode_next = ccs_pkg::MODE_BLOCK;
            end
          end
          ccs_pkg::MODE_LCOM: begin
            if (in_byte == ccs_pkg::CH_NL) mode_next = ccs_pkg::MODE_LINE;
          end
          ccs_pkg::MODE_STR: begin
            if (in_byte == ccs_pkg::CH_DQ) begin
              mode_next = ccs_pkg::MODE_MID;
            end else if (in_byte == ccs_pkg::CH_BSL) begin
              mode_next = ccs_pkg::MODE_SBS1;
            end
          end
          ccs_pkg::MODE_SBS1: begin
            mode_next = ccs_pkg::is_digit(in_byte) ? ccs_pkg::MODE_SBS2 : ccs_pkg::MODE_STR;
          end
          ccs_pkg::MODE_SBS2: begin
            if (ccs_pkg::is_digit(in_byte)) mode_next = ccs_pkg::MODE_SBS3;
            else halted_next = 1'b1;
          end
          ccs_pkg::MODE_SBS3: begin
            if (ccs_pkg::is_digit(in_byte)) mode_next = ccs_pkg::MODE_STR;
            else halted_next = 1'b1;
          end
          ccs_pkg::MODE_CHR1: begin
            mode_next = (in_byte == ccs_pkg::CH_BSL) ? ccs_pkg::MODE_CHRESC
                                                     : ccs_pkg::MODE_CHREND;
          end
          ccs_pkg::MODE_CHRESC: begin
            mode_next = ccs_pkg::MODE_CHREND;
          end
          ccs_pkg::MODE_CHREND: begin
            if (in_byte == ccs_pkg::CH_SQ) mode_next = ccs_pkg::MODE_MID;
            else halted_next = 1'b1;
          end
          default: begin
            // line start, mid line, and any code without meaning
            if (in_byte == ccs_pkg::CH_SLASH) begin
              mode_next = ccs_pkg::MODE_SLASH;
            end else begin
              mode_next = ccs_pkg::code_mode(in_byte);
              if (in_byte == ccs_pkg::CH_DQ) lit_len_next = 10'd1;
            end
          end
        endcase
      end
    end
  end

  // command for the back end
  always_comb begin
    cmd_push     = 1'b0;
    cmd.two      = 1'b0;
    cmd.byte0    = in_byte;
    cmd.byte1    = in_byte;
    cmd.has_byte = 1'b1;
    cmd.status   = ccs_pkg::ST_OK;
    if (in_eot) begin
      cmd_push     = 1'b1;
      cmd.byte0    = 8'd0;
      cmd.has_byte = 1'b0;
      case (mode)
        ccs_pkg::MODE_SLASH, ccs_pkg::MODE_BLOCK, ccs_pkg::MODE_BSTAR,
        ccs_pkg::MODE_LCOM, ccs_pkg::MODE_STR, ccs_pkg::MODE_SBS1,
        ccs_pkg::MODE_SBS2, ccs_pkg::MODE_SBS3, ccs_pkg::MODE_CHR1,
        ccs_pkg::MODE_CHRESC, ccs_pkg::MODE_CHREND: cmd.status = ccs_pkg::ST_PREMATURE;
        default: cmd.status = ccs_pkg::ST_OK;
      endcase
    end else if (overlong) begin
      cmd_push     = 1'b1;
      cmd.byte0    = 8'd0;
      cmd.has_byte = 1'b0;
      cmd.status   = ccs_pkg::ST_OVERLONG;
    end else begin
      case (mode)
        ccs_pkg::MODE_SLASH: begin
          if ((in_byte != ccs_pkg::CH_STAR) && (in_byte != ccs_pkg::CH_SLASH)) begin
            cmd_push  = 1'b1;
            cmd.two   = 1'b1;
            cmd.byte0 = ccs_pkg::CH_SLASH;
          end
        end
        ccs_pkg::MODE_BLOCK, ccs_pkg::MODE_BSTAR, ccs_pkg::MODE_LCOM: begin
          cmd_push = (in_byte == ccs_pkg::CH_NL);
        end
        ccs_pkg::MODE_STR, ccs_pkg::MODE_SBS1, ccs_pkg::MODE_CHR1,
        ccs_pkg::MODE_CHRESC: begin
          cmd_push = 1'b1;
        end
        ccs_pkg::MODE_SBS2, ccs_pkg::MODE_SBS3: begin
          cmd_push = 1'b1;
          if (!ccs_pkg::is_digit(in_byte)) begin
            cmd.byte0    = 8'd0;
            cmd.has_byte = 1'b0;
            cmd.status   = ccs_pkg::ST_BAD_OCTAL;
          end
        end
        ccs_pkg::MODE_CHREND: begin
          cmd_push = 1'b1;
          if (in_byte != ccs_pkg::CH_SQ) begin
            cmd.byte0    = 8'd0;
            cmd.has_byte = 1'b0;
            cmd.status   = ccs_pkg::ST_BAD_CHAR;
          end
        end
        default: begin
          cmd_push = (in_byte != ccs_pkg::CH_SLASH);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= ccs_pkg::MODE_LINE;
      lit_len <= '0;
      halted  <= 1'b0;
      max_len <= ccs_pkg::MAX_LIT_RESET;
    end else begin
      mode    <= mode_next;
      lit_len <= lit_len_next;
      halted  <= halted_next;
      if (cfg_valid) begin
        max_len <= cfg_data;
      end
    end
  end

endmodule

@@ hw/rtl/ccs_back.sv @@
// Output back end: expands queued commands into result words, one per cycle unless stalled.
module ccs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  ccs_pkg::cmd_t cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_has,
  output ccs_pkg::status_t out_status,
  output logic          out_last
);

  logic       pend_valid;
  logic [7:0] pend_byte;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign pop      = out_free && !pend_valid && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_free) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        out_valid  <= !empty;
        pend_valid <= !empty && cmd.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid) begin
        out_byte   <= pend_byte;
        out_has    <= 1'b1;
        out_status <= ccs_pkg::ST_OK;
        out_last   <= 1'b1;
      end else begin
        out_byte   <= cmd.byte0;
        out_has    <= cmd.has_byte;
        out_status <= cmd.status;
        out_last   <= !cmd.two;
        pend_byte  <= cmd.byte1;
      end
    end
  end

endmodule

@@ hw/rtl/ccs_checker.sv @@
// Port-level checker for the comment stripper, bound to the top level.
`include "c_comment_stripper_core_defines.svh"

module ccs_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // stalled output word holds
  `CCS_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // status words close their run and carry no byte
  `CCS_ASSERT_IMPLY(a_status_word, clk, rst, m_tvalid && !m_tuser, m_tlast && (m_tdata[7:0] == 8'd0))

  // byte words always report ok status
  `CCS_ASSERT_IMPLY(a_byte_ok, clk, rst, m_tvalid && m_tuser, m_tdata[10:8] == 3'd0)

  // status code in range, padding zero
  `CCS_ASSERT_IMPLY(a_status_range, clk, rst, m_tvalid, (m_tdata[10:8] <= 3'd4) && (m_tdata[15:11] == 5'd0))

endmodule

bind c_comment_stripper_core ccs_checker u_ccs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
